// ===== rtl/lfo_swept_bandpass_filter_core_macros.svh =====
// Assertion macros for the swept bandpass filter core.
// No dependencies; included by modules that carry checks.
`ifndef LFO_SWEPT_BANDPASS_FILTER_CORE_MACROS_SVH
`define LFO_SWEPT_BANDPASS_FILTER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define LSBP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define LSBP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define LSBP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LSBP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/lsbp_pkg.sv =====
// Shared types, constants and functions for the swept bandpass filter.
// No dependencies.
package lsbp_pkg;
	localparam int ChannelCount = 2;
	localparam int PhaseBits = 24;
	localparam int SineTableDepth = 1024;
	localparam int SineAddrBits = $clog2(SineTableDepth);

	localparam logic [2:0] REG_LFO_STEP = 3'd0;
	localparam logic [2:0] REG_CENTER = 3'd1;
	localparam logic [2:0] REG_DEPTH = 3'd2;
	localparam logic [2:0] REG_GAIN_A0 = 3'd3;
	localparam logic [2:0] REG_POLE_SCALE = 3'd4;
	localparam logic [2:0] REG_FEEDBACK_B2 = 3'd5;

	localparam logic [31:0] SC1 = 32'd1686629713;
	localparam logic [31:0] SC3 = 32'd693598668;
	localparam logic [31:0] SC5 = 32'd85569305;
	localparam logic [31:0] SC7 = 32'd5026995;
	localparam logic [31:0] SC9 = 32'd172274;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SIN, ST_SWEEP, ST_COS, ST_B1, ST_LANE, ST_OUT
	} seq_state_t;

	// sine unit polynomial steps
	typedef enum logic [2:0] {
		SN_IDLE, SN_SQ, SN_POLY, SN_FIN, SN_DONE
	} sin_state_t;

	typedef struct packed {
		logic start;
		logic load;
	} lane_ctl_t;

	function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction
endpackage

// ===== rtl/lsbp_sine.sv =====
// Multi-cycle sine unit: 16-bit circle angle in, signed Q30 sine out.
// Depends on lsbp_pkg; one 32x32 product per cycle, Horner polynomial.
module lsbp_sine
	import lsbp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [15:0]        angle,
	output logic               done,
	output logic signed [31:0] sine
);
	sin_state_t st_q, st_d;
	logic [31:0] z_q, z2_q, p_q;
	logic [2:0]  k_q;
	logic        neg_q;
	logic [63:0] prod;
	logic [31:0] a, b, coef, pnext;
	logic [13:0] r;

	always_comb begin
		r = angle[14] ? 14'(15'd16384 - {1'b0, angle[13:0]}) : angle[13:0];
		if (angle[14] && angle[13:0] == 14'd0) r = 14'd0;
		unique case (st_q)
			SN_SQ: begin a = z_q; b = z_q; end
			SN_FIN: begin a = p_q; b = z_q; end
			default: begin a = p_q; b = z2_q; end
		endcase
		prod = 64'(a) * 64'(b);
		unique case (k_q)
			3'd0: coef = SC7;
			3'd1: coef = SC5;
			3'd2: coef = SC3;
			default: coef = SC1;
		endcase
		pnext = coef - prod[61:30];
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			SN_IDLE: if (start) st_d = SN_SQ;
			SN_SQ: st_d = SN_POLY;
			SN_POLY: if (k_q == 3'd3) st_d = SN_FIN;
			SN_FIN: st_d = SN_DONE;
			SN_DONE: st_d = SN_IDLE;
			default: st_d = SN_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= SN_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			SN_IDLE: begin
				// angle[14:0] of 16384 exactly: r wraps to 0, handled as full quarter
				if (angle[14] && angle[13:0] == 14'd0) z_q <= 32'd16384 << 16;
				else z_q <= {2'b0, r, 16'b0};
				neg_q <= angle[15];
				k_q <= 3'd0;
				p_q <= SC9;
			end
			SN_SQ: z2_q <= prod[61:30];
			SN_POLY: begin p_q <= pnext; k_q <= k_q + 3'd1; end
			SN_FIN: p_q <= (prod[63:30] > 34'd1073741824) ? 32'd1073741824 : prod[61:30];
			default: ;
		endcase
	end

	assign done = (st_q == SN_DONE);
	assign sine = neg_q ? -$signed(p_q) : $signed(p_q);
endmodule

// ===== rtl/lsbp_lane.sv =====
// One biquad channel lane: history registers and multi-cycle accumulate.
// Depends on lsbp_pkg.
module lsbp_lane
	import lsbp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  lane_ctl_t          ctl,
	input  logic signed [15:0] x0,
	input  logic [30:0]        gain_a0,
	input  logic signed [31:0] b1n,
	input  logic [30:0]        feedback_b2,
	output logic signed [15:0] result
);
	logic signed [15:0] x1_q, x2_q;
	logic signed [31:0] y1_q, y2_q;
	logic signed [63:0] acc_q;
	logic [1:0] step_q;
	logic signed [63:0] term, y0, yt;
	logic signed [16:0] dx;
	logic signed [31:0] ya;

	function automatic logic signed [63:0] sat16(input logic signed [63:0] v);
		if (v > 64'sd32767) return 64'sd32767;
		if (v < -64'sd32768) return -64'sd32768;
		return v;
	endfunction

	always_comb begin
		dx = 17'(x0) - 17'(x2_q);
		unique case (step_q)
			2'd0: term = ($signed({1'b0, gain_a0}) * (64'(dx) <<< 8)) >>> 30;
			2'd1: term = (64'(b1n) * 64'(y1_q)) >>> 30;
			default: term = -((64'($signed({1'b0, feedback_b2})) * 64'(y2_q)) >>> 30);
		endcase
		y0 = sat32(acc_q);
		yt = (y0 >= 0) ? (y0 >>> 8) : -((-y0) >>> 8);
		ya = 32'(y0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q <= '0; x2_q <= '0; y1_q <= '0; y2_q <= '0;
			step_q <= 2'd3; acc_q <= '0; result <= '0;
		end else if (ctl.start) begin
			step_q <= 2'd0; acc_q <= '0;
		end else if (step_q != 2'd3) begin
			acc_q <= acc_q + term;
			step_q <= step_q + 2'd1;
		end else if (ctl.load) begin
			x2_q <= x1_q; x1_q <= x0; y2_q <= y1_q; y1_q <= ya;
			result <= 16'(sat16(yt));
		end
	end
endmodule

// ===== rtl/lfo_swept_bandpass_filter_core.sv =====
// LFO-swept stereo bandpass filter core.
// Frames are handled one at a time: a new input request is accepted only in idle,
// after two passes through the shared sine unit, sweep, b1, the lane steps and
// output, and the output state holds until m_tready is seen.
// Reset (arst_n low): LFO phase, histories and configuration registers return to defaults.
// Depends on lsbp_pkg, lsbp_sine, lsbp_lane and the macro header.
`include "lfo_swept_bandpass_filter_core_macros.svh"
module lfo_swept_bandpass_filter_core
	import lsbp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [30:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // sample_left [15:0], sample_right [31:16]
	input  logic        s_tlast,   // last_in_buffer
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // filtered_left [15:0], filtered_right [31:16]
	output logic        m_tlast    // last_out
);
	logic [19:0] lfo_step_q;
	logic [22:0] center_q, depth_q;
	logic [30:0] gain_q, pole_q, fb_q;
	logic [PhaseBits-1:0] phase_q;
	seq_state_t st_q, st_d;
	logic [31:0] in_q;
	logic last_q;
	logic signed [31:0] s_q, b1_q;
	logic [PhaseBits-1:0] band;
	logic [15:0] angle;
	logic sin_start, sin_done;
	logic signed [31:0] sine;
	logic [2:0] cnt_q;
	lane_ctl_t ctl;
	logic signed [15:0] res [ChannelCount];
	logic signed [63:0] sw, b1w;

	// register writes, out-of-range indices drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfo_step_q <= 20'd76; center_q <= 23'd760871; depth_q <= 23'd684784;
			gain_q <= 31'd3811000; pole_q <= 31'd1069931000; fb_q <= 31'd1066120000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LFO_STEP: lfo_step_q <= cfg_data[19:0];
				REG_CENTER: center_q <= cfg_data[22:0];
				REG_DEPTH: depth_q <= cfg_data[22:0];
				REG_GAIN_A0: gain_q <= cfg_data;
				REG_POLE_SCALE: pole_q <= cfg_data;
				REG_FEEDBACK_B2: fb_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// LFO angle quantised to table points, then spread over the 16-bit circle;
	// the band angle is the top 16 bits of the sweep sum plus a quarter turn, as the cosine starts
	always_comb begin
		sw = (64'(s_q) * 64'($signed({1'b0, depth_q}))) >>> 30;
		band = PhaseBits'(64'(center_q) + sw);
		if (st_q == ST_SWEEP)
			angle = 16'(band[PhaseBits-1 -: 16] + 16'd16384);
		else
			angle = {phase_q[PhaseBits-1 -: SineAddrBits], {(16 - SineAddrBits){1'b0}}};
		b1w = sat32((64'($signed({1'b0, pole_q})) * (64'(sine) <<< 1)) >>> 30);
	end

	assign sin_start = (st_q == ST_IDLE && s_tvalid) || (st_q == ST_SWEEP);

	lsbp_sine u_sine (
		.clk(clk), .arst_n(arst_n), .start(sin_start), .angle(angle),
		.done(sin_done), .sine(sine)
	);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (s_tvalid) st_d = ST_SIN;
			ST_SIN: if (sin_done) st_d = ST_SWEEP;
			ST_SWEEP: st_d = ST_COS;
			ST_COS: if (sin_done) st_d = ST_B1;
			ST_B1: st_d = ST_LANE;
			ST_LANE: if (cnt_q == 3'd3) st_d = ST_OUT;
			ST_OUT: if (m_tready) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (st_q == ST_IDLE);
		m_tvalid = (st_q == ST_OUT);
		ctl.start = (st_q == ST_B1);
		ctl.load = (st_q == ST_LANE) && (cnt_q == 3'd3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; phase_q <= '0; cnt_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_SIN && sin_done)
				phase_q <= phase_q + PhaseBits'(lfo_step_q);
			if (st_q == ST_B1) cnt_q <= '0;
			else if (st_q == ST_LANE) cnt_q <= cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin in_q <= s_tdata; last_q <= s_tlast; end
		if (st_q == ST_SIN && sin_done) s_q <= sine;
		if (st_q == ST_COS && sin_done) b1_q <= 32'(b1w);
	end

	for (genvar c = 0; c < ChannelCount; c++) begin : g_lane
		lsbp_lane u_lane (
			.clk(clk), .arst_n(arst_n), .ctl(ctl),
			.x0((c < 2) ? $signed(in_q[16*(c%2) +: 16]) : 16'sd0),
			.gain_a0(gain_q), .b1n(b1_q), .feedback_b2(fb_q), .result(res[c])
		);
	end

	// merge lane results
	assign m_tdata = {(ChannelCount > 1) ? res[(ChannelCount > 1) ? 1 : 0] : 16'sd0, res[0]};
	assign m_tlast = last_q;

	`LSBP_ASSERT_IMP(a_one_side, clk, arst_n, 1'b1, !(s_tready && m_tvalid))
	`LSBP_ASSERT_NXT(a_acc_sin, clk, arst_n, s_tvalid && s_tready, st_q == ST_SIN)
	`LSBP_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
endmodule

// ===== test/tb_lfo_swept_bandpass_filter_core.sv =====
// Testbench for the LFO-swept stereo bandpass filter core: directed and random frames
// are checked against a predictor of the sweep, the biquads and the saturation.
// Depends on lsbp_pkg and the lfo_swept_bandpass_filter_core RTL.
`timescale 1ns / 1ps
module tb_lfo_swept_bandpass_filter_core;
	import lsbp_pkg::*;

	localparam int CycleLimit = 1000000;
	localparam int DrainCycles = 60;

	typedef struct {
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic               last;
	} frame_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [30:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;

	lfo_swept_bandpass_filter_core dut (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.s_tvalid, .s_tready, .s_tdata, .s_tlast,
		.m_tvalid, .m_tready, .m_tdata, .m_tlast
	);

	always #1 clk = ~clk;

	// Predictor state: registers, LFO phase and per-channel histories
	logic [19:0] m_step;
	logic [22:0] m_center, m_depth;
	logic [30:0] m_a0, m_pole, m_b2;
	logic [23:0] m_phase;
	logic signed [15:0] x_hist [2][2];
	logic signed [63:0] y_hist [2][2];

	frame_t filtered_q[$];
	int     mismatches = 0;
	int     accepted = 0;
	int     burst_left = 0;
	logic   hold_off = 1'b0;
	int     cycles = 0;

	// Quarter-wave sine polynomial in Q30, angle r on a 16384-step quarter
	function automatic logic signed [63:0] quarter_wave(input logic [15:0] r);
		logic [63:0] z, z2, p;
		z = 64'(r) << 16;
		z2 = (z * z) >> 30;
		p = 64'(SC9);
		p = 64'(SC7) - ((p * z2) >> 30);
		p = 64'(SC5) - ((p * z2) >> 30);
		p = 64'(SC3) - ((p * z2) >> 30);
		p = 64'(SC1) - ((p * z2) >> 30);
		p = (p * z) >> 30;
		if (p > 64'd1073741824)
			p = 64'd1073741824;
		return $signed(p);
	endfunction

	function automatic logic signed [63:0] circle_sine(input logic [15:0] u);
		logic [15:0] r;
		logic signed [63:0] m;
		r = {2'b00, u[13:0]};
		if (u[14])
			r = 16'd16384 - r;
		m = quarter_wave(r);
		return u[15] ? -m : m;
	endfunction

	function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Advance the predictor by one frame and queue the filtered frame
	task automatic predict_filtered(input logic [31:0] data, input logic lst);
		logic signed [63:0] s, sw, d, b1n, x0, x2, acc, y0, t;
		logic [23:0] band;
		logic [15:0] u;
		frame_t f;
		logic signed [15:0] res [2];
		// LFO angle quantised to the table depth: k = phase >> 14, u = k << 6
		u = {m_phase[23:14], 6'b0};
		s = circle_sine(u);
		m_phase = m_phase + 24'(m_step);
		sw = (s * $signed({41'b0, m_depth})) >>> 30;
		band = 24'($signed({41'b0, m_center}) + sw);
		u = band[23:8] + 16'd16384;
		d = 2 * circle_sine(u);
		b1n = clamp32(($signed({33'b0, m_pole}) * d) >>> 30);
		for (int c = 0; c < 2; c++) begin
			x0 = (c == 0) ? $signed(data[15:0]) : $signed(data[31:16]);
			x2 = x_hist[c][1];
			acc = (($signed({33'b0, m_a0}) * ((x0 - x2) * 256)) >>> 30)
				+ ((b1n * y_hist[c][0]) >>> 30)
				- (($signed({33'b0, m_b2}) * y_hist[c][1]) >>> 30);
			y0 = clamp32(acc);
			x_hist[c][1] = x_hist[c][0];
			x_hist[c][0] = 16'(x0);
			y_hist[c][1] = y_hist[c][0];
			y_hist[c][0] = y0;
			// truncate toward zero, then saturate to 16 bits
			t = (y0 >= 0) ? (y0 >>> 8) : -((-y0) >>> 8);
			if (t > 32767) t = 32767;
			if (t < -32768) t = -32768;
			res[c] = 16'(t);
		end
		f.left = res[0];
		f.right = res[1];
		f.last = lst;
		filtered_q.push_back(f);
	endtask

	// Offer one frame; hold the request until accepted, then maybe drop into a gap
	task automatic send_frame(input logic [15:0] l, input logic [15:0] r, input logic lst);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= {r, l};
		s_tlast <= lst;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_filtered({r, l}, lst);
		accepted++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Let the block go idle: every result back, then the DrainCycles wait
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (filtered_q.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [30:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_LFO_STEP:    m_step = val[19:0];
			REG_CENTER:      m_center = val[22:0];
			REG_DEPTH:       m_depth = val[22:0];
			REG_GAIN_A0:     m_a0 = val;
			REG_POLE_SCALE:  m_pole = val;
			REG_FEEDBACK_B2: m_b2 = val;
			default: ;
		endcase
	endtask

	task automatic load_defaults();
		cfg_write(REG_LFO_STEP, 31'd76);
		cfg_write(REG_CENTER, 31'd760871);
		cfg_write(REG_DEPTH, 31'd684784);
		cfg_write(REG_GAIN_A0, 31'd3811000);
		cfg_write(REG_POLE_SCALE, 31'd1069931000);
		cfg_write(REG_FEEDBACK_B2, 31'd1066120000);
	endtask

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($signed($urandom_range(0, 511)) - 256);
			default: return 16'($urandom);
		endcase
	endfunction

	// Directed frames at reset defaults: sample extremes, zero, and both tlast values
	task automatic test_default_extremes();
		logic [15:0] pat [6] = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001, 16'h5555};
		for (int i = 0; i < 6; i++)
			send_frame(pat[i], pat[5 - i], i[0]);
		for (int i = 0; i < 4; i++)
			send_frame(16'h7fff, 16'h8000, 1'b1);
		drain();
	endtask

	// Extreme register settings: wrapping band, clamped b1, saturating output; then zeroed tunings
	task automatic test_register_extremes();
		cfg_write(REG_LFO_STEP, 31'hfffff);
		cfg_write(REG_CENTER, 31'h7fffff);
		cfg_write(REG_DEPTH, 31'h7fffff);
		cfg_write(REG_GAIN_A0, 31'h7fffffff);
		cfg_write(REG_POLE_SCALE, 31'h7fffffff);
		cfg_write(REG_FEEDBACK_B2, 31'h7fffffff);
		// index outside the register list: must leave everything unchanged
		cfg_write(3'd6, 31'h0);
		cfg_write(3'd7, 31'h12345);
		for (int i = 0; i < 8; i++)
			send_frame(i[0] ? 16'h7fff : 16'h8000, i[1] ? 16'h8000 : 16'h7fff, 1'b0);
		drain();
		cfg_write(REG_CENTER, 31'd0);
		cfg_write(REG_GAIN_A0, 31'd0);
		cfg_write(REG_POLE_SCALE, 31'd0);
		cfg_write(REG_FEEDBACK_B2, 31'd0);
		cfg_write(REG_LFO_STEP, 31'd0);
		for (int i = 0; i < 4; i++)
			send_frame(16'h7fff, 16'h8000, 1'b1);
		drain();
	endtask

	// Random frames across several register phases; mostly stable, near-default tunings
	task automatic test_random_phases();
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 0) begin
				load_defaults();
			end else if (ph % 2 == 1) begin
				cfg_write(REG_LFO_STEP, 31'($urandom_range(0, 20'hfffff)));
				cfg_write(REG_CENTER, 31'($urandom_range(0, 23'h7fffff)));
				cfg_write(REG_DEPTH, 31'($urandom_range(0, 23'h7fffff)));
				cfg_write(REG_GAIN_A0, 31'($urandom_range(0, 31'd50000000)));
				cfg_write(REG_POLE_SCALE, 31'($urandom_range(31'd900000000, 31'd1073741823)));
				cfg_write(REG_FEEDBACK_B2, 31'($urandom_range(31'd800000000, 31'd1070000000)));
			end else begin
				cfg_write(REG_LFO_STEP, 31'($urandom) & 31'hfffff);
				cfg_write(REG_CENTER, 31'($urandom) & 31'h7fffff);
				cfg_write(REG_DEPTH, 31'($urandom) & 31'h7fffff);
				cfg_write(REG_GAIN_A0, 31'($urandom));
				cfg_write(REG_POLE_SCALE, 31'($urandom));
				cfg_write(REG_FEEDBACK_B2, 31'($urandom));
			end
			for (int i = 0; i < 300; i++)
				send_frame(rand_sample(), rand_sample(), ($urandom_range(0, 7) == 0));
			drain();
		end
	endtask

	// Receiver: stall pattern follows cycle counter bits 9:8; the long hold overrides it
	always @(posedge clk) begin
		if (hold_off) begin
			m_tready <= 1'b0;
		end else begin
			case (cycles[9:8])
				2'd0: m_tready <= 1'b1;
				2'd1: m_tready <= ($urandom_range(0, 3) != 0);
				2'd2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= cycles[2];
			endcase
		end
	end

	// Long hold-off once the random part is under way, so the input backs up
	initial begin
		wait (accepted >= 400);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (500) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Compare each accepted result with the oldest expected frame
	always @(posedge clk) begin
		frame_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (filtered_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h last %b", m_tdata, m_tlast);
			end else begin
				e = filtered_q.pop_front();
				if (m_tdata[15:0] !== e.left || m_tdata[31:16] !== e.right
						|| m_tlast !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected L %0d R %0d last %b, got L %0d R %0d last %b",
							e.left, e.right, e.last, $signed(m_tdata[15:0]),
							$signed(m_tdata[31:16]), m_tlast);
				end
			end
		end
	end

	// Timeout watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("tb_lfo_swept_bandpass_filter_core: errors");
			$finish;
		end
	end

	initial begin
		m_step = 20'd76;
		m_center = 23'd760871;
		m_depth = 23'd684784;
		m_a0 = 31'd3811000;
		m_pole = 31'd1069931000;
		m_b2 = 31'd1066120000;
		m_phase = '0;
		for (int c = 0; c < 2; c++)
			for (int j = 0; j < 2; j++) begin
				x_hist[c][j] = '0;
				y_hist[c][j] = '0;
			end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_extremes();
		test_register_extremes();
		test_random_phases();
		drain();
		if (mismatches == 0 && filtered_q.size() == 0)
			$display("tb_lfo_swept_bandpass_filter_core: clean");
		else
			$display("tb_lfo_swept_bandpass_filter_core: errors");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/lsbp_pkg.sv
rtl/lsbp_sine.sv
rtl/lsbp_lane.sv
rtl/lfo_swept_bandpass_filter_core.sv
test/tb_lfo_swept_bandpass_filter_core.sv
